@@ rtl/morusinv_pkg.sv @@
// Package with the types, constants and sub-round function of the MORUS-640 inverse state update.
`default_nettype none
package morusinv_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Rows = 5;
  localparam int unsigned Cols = 4;
  localparam logic [4:0] StateWords = 5'd20;

  localparam int unsigned RotA = 19;
  localparam int unsigned RotB = 10;
  localparam int unsigned RotC = 25;
  localparam int unsigned RotD = 1;
  localparam int unsigned RotE = 27;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [Cols-1:0] row_t;
  typedef row_t [Rows-1:0] state_t;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_STEP = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  // Packed so that the last field, mode, sits in the lowest bits.
  typedef struct packed {
    word_t      msg_word3;
    word_t      msg_word2;
    word_t      msg_word1;
    word_t      msg_word0;
    word_t      word_value;
    logic [4:0] word_index;
    mode_e      mode;
  } in_item_t;

  typedef struct packed {
    logic     fire;
    in_item_t item;
  } state_cmd_t;

  function automatic word_t rol(word_t x, int unsigned bits);
    return (x << bits) | (x >> (WordW - bits));
  endfunction

  // One inverse sub-round: rotate row rr by k words, then mix into row tgt.
  function automatic state_t sub_round(state_t s, int unsigned rr, int unsigned k,
                                       int unsigned tgt, int unsigned bits,
                                       int unsigned a, int unsigned b, int unsigned c,
                                       row_t msg);
    state_t     r;
    logic [1:0] j;
    r = s;
    for (int unsigned i = 0; i < Cols; i++) begin
      j = 2'(i + k);
      r[rr][i] = s[rr][j];
    end
    for (int unsigned i = 0; i < Cols; i++) begin
      r[tgt][i] = rol(r[tgt][i], bits) ^ (r[a][i] & r[b][i]) ^ r[c][i] ^ msg[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/morusinv_update.sv @@
// Combinational inverse state update: five sub-rounds in reverse order.
`default_nettype none
module morusinv_update (
  input  morusinv_pkg::state_t state_i,
  input  morusinv_pkg::row_t   msg_i,
  output morusinv_pkg::state_t state_o
);

  morusinv_pkg::state_t s1, s2, s3, s4;

  assign s1 = morusinv_pkg::sub_round(state_i, 2, 1, 4, morusinv_pkg::RotA, 0, 1, 2, msg_i);
  assign s2 = morusinv_pkg::sub_round(s1, 1, 2, 3, morusinv_pkg::RotB, 4, 0, 1, msg_i);
  assign s3 = morusinv_pkg::sub_round(s2, 0, 3, 2, morusinv_pkg::RotC, 3, 4, 0, msg_i);
  assign s4 = morusinv_pkg::sub_round(s3, 4, 2, 1, morusinv_pkg::RotD, 2, 3, 4, msg_i);
  assign state_o = morusinv_pkg::sub_round(s4, 3, 1, 0, morusinv_pkg::RotE, 1, 2, 3, '0);

endmodule
`default_nettype wire

@@ rtl/morusinv_state.sv @@
// Cipher state registers with load, update step and read of the addressed word.
`default_nettype none
module morusinv_state (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  morusinv_pkg::state_cmd_t   cmd_i,
  output morusinv_pkg::word_t        word_o
);

  morusinv_pkg::state_t state_q, state_d, stepped;
  morusinv_pkg::row_t   msg;
  logic [2:0]           row;
  logic [1:0]           col;
  logic                 idx_ok;

  assign row    = cmd_i.item.word_index[4:2];
  assign col    = cmd_i.item.word_index[1:0];
  assign idx_ok = cmd_i.item.word_index < morusinv_pkg::StateWords;
  assign msg    = {cmd_i.item.msg_word3, cmd_i.item.msg_word2,
                   cmd_i.item.msg_word1, cmd_i.item.msg_word0};

  morusinv_update u_update (
    .state_i (state_q),
    .msg_i   (msg),
    .state_o (stepped)
  );

  always_comb begin
    state_d = state_q;
    if (cmd_i.fire) begin
      case (cmd_i.item.mode)
        morusinv_pkg::MODE_LOAD: begin
          if (idx_ok) begin
            state_d[row][col] = cmd_i.item.word_value;
          end
        end
        morusinv_pkg::MODE_STEP: begin
          state_d = stepped;
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  assign word_o = idx_ok ? state_d[row][col] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/morus640_inverse_state_update.sv @@
// An accepted item waits in the input register; its result is then captured in the result register.
// Throughput: one item per cycle unless the result stalls; the update runs between the registers.
// A stalled result holds the pipeline; the input register still frees when the result leaves.
// Reset clears the whole 640-bit state to zero and empties both registers.
// Top level of the MORUS-640 inverse state update block.
`default_nettype none
module morus640_inverse_state_update (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           s_axis_tvalid,
  output logic          s_axis_tready,
  // mode, word_index, word_value, msg_word0, msg_word1, msg_word2, msg_word3, zero pad.
  input  wire  [167:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  wire           m_axis_tready,
  // state_word.
  output logic [31:0]   m_axis_tdata
);

  logic                       in_valid_q;
  morusinv_pkg::in_item_t     in_q;
  logic                       out_valid_q;
  morusinv_pkg::word_t        out_q;
  morusinv_pkg::word_t        word;
  morusinv_pkg::state_cmd_t   cmd;
  logic                       adv;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;

  assign cmd.fire = in_valid_q && adv;
  assign cmd.item = in_q;

  morusinv_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .word_o (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= morusinv_pkg::in_item_t'(s_axis_tdata[166:0]);
    end
    if (cmd.fire) begin
      out_q <= word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_in_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire |=> out_valid_q)
    else $error("processed item produced no result");

  a_bad_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fire && (in_q.word_index >= morusinv_pkg::StateWords)) |=> (m_axis_tdata == '0))
    else $error("out of range index did not return zero");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=> in_valid_q)
    else $error("pending item lost during output stall");

endmodule
`default_nettype wire
